/* hw/rtl/swog_pkg.sv */
// ============================================================================
// swog_pkg
// Shared parameters, codes and tables for the scanline wave offset generator.
// ============================================================================
package swog_pkg;

  localparam int DEF_LINES  = 256;
  localparam int WAVE_STEPS = 256;
  localparam int THETA_W    = $clog2(WAVE_STEPS);
  localparam int SINE_W     = 9;
  localparam int PROD_W     = 17;

  localparam logic [1:0] CMD_START = 2'd0;
  localparam logic [1:0] CMD_FRAME = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  localparam logic [2:0] REG_START_LINE = 3'd0;
  localparam logic [2:0] REG_END_LINE   = 3'd1;
  localparam logic [2:0] REG_FREQUENCY  = 3'd2;
  localparam logic [2:0] REG_AMPLITUDE  = 3'd3;
  localparam logic [2:0] REG_DELAY      = 3'd4;
  localparam logic [2:0] REG_APPLY_BG   = 3'd5;

  localparam logic [SINE_W-1:0] QUARTER_SINE [65] = '{
    9'd0,   9'd6,   9'd12,  9'd18,  9'd25,  9'd31,  9'd37,  9'd43,
    9'd49,  9'd56,  9'd62,  9'd68,  9'd74,  9'd80,  9'd86,  9'd92,
    9'd97,  9'd103, 9'd109, 9'd115, 9'd120, 9'd126, 9'd131, 9'd136,
    9'd142, 9'd147, 9'd152, 9'd157, 9'd162, 9'd167, 9'd171, 9'd176,
    9'd181, 9'd185, 9'd189, 9'd193, 9'd197, 9'd201, 9'd205, 9'd209,
    9'd212, 9'd216, 9'd219, 9'd222, 9'd225, 9'd228, 9'd231, 9'd234,
    9'd236, 9'd238, 9'd241, 9'd243, 9'd244, 9'd246, 9'd248, 9'd249,
    9'd251, 9'd252, 9'd253, 9'd254, 9'd254, 9'd255, 9'd255, 9'd255,
    9'd256
  };

  // magnitude of the sine for the low seven bits of the angle
  function automatic logic [SINE_W-1:0] sine_mag(input logic [6:0] t);
    logic [7:0] idx;
    idx = (t <= 7'd64) ? {1'b0, t} : (8'd128 - {1'b0, t});
    return QUARTER_SINE[idx[6:0]];
  endfunction

endpackage

/* hw/rtl/scanline_wave_offset_generator.sv */
// ============================================================================
// scanline_wave_offset_generator
// Double-buffered per-scanline scroll offsets carrying a travelling sine wave.
// ============================================================================
// channel | direction | handshake           | payload
// --------+-----------+---------------------+----------------------------------
// in_     | input     | in_valid / in_stall | in_cmd, in_bg_offset, in_line
// out_    | output    | out_valid/out_stall | out_line_value, out_line_echo
// APB     | input     | psel/penable/pready | paddr, pwdata, prdata
//
// Read: accept with line store read, then read state. Frame: phase and head,
// then multiply, write, head per filled line. Start: 9-step divider for wave
// length, then both banks written through the single line store write port.
// One shared multiplier forms the start angle and every sine * amplitude term.
// Synchronous active-low reset; line store is not cleared, reads outside the
// latched range return 0 without touching it.
// A stalled result holds the read state; the input stays stalled meanwhile.
module scanline_wave_offset_generator #(
  parameter int LINES = swog_pkg::DEF_LINES
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_cmd,
  input  logic [15:0] in_bg_offset,
  input  logic [7:0]  in_line,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_line_value,
  output logic [7:0]  out_line_echo,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int DEPTH = 2 * LINES;
  localparam int AW    = $clog2(DEPTH);
  localparam logic [AW-1:0] BANK1_BASE = AW'(LINES);
  localparam logic [8:0]    LINES_9    = 9'(LINES);

  typedef enum logic [2:0] {
    ST_IDLE, ST_DIV, ST_PHASE, ST_HEAD, ST_MUL, ST_WR0, ST_WR1, ST_RD
  } state_t;

  state_t state_r;

  logic [7:0] reg_start_r, reg_end_r, reg_freq_r, reg_amp_r, reg_delay_r;
  logic       reg_apply_r;
  logic [7:0] lat_start_r, lat_end_r, lat_freq_r, lat_amp_r, lat_delay_r;
  logic       lat_apply_r;
  logic       active_r;
  logic       write_bank_r;
  logic [7:0] wave_phase_r;
  logic [8:0] wave_length_r;
  logic [7:0] frames_left_r;

  logic [7:0] div_rem_r;
  logic [7:0] div_quo_r;
  logic [3:0] div_cnt_r;

  logic                       fill_bank_r;
  logic                       both_r;
  logic [15:0]                add_r;
  logic [7:0]                 i_r;
  logic [swog_pkg::THETA_W-1:0] theta_r;
  logic [swog_pkg::PROD_W-1:0]  prod_r;
  logic                       neg_r;

  logic        in_range_r;
  logic [7:0]  rd_line_r;
  logic [15:0] mem_q_r;
  logic        out_valid_r;
  logic [15:0] out_line_value_r;
  logic [7:0]  out_line_echo_r;

  logic [15:0] mem [DEPTH];

  logic                        in_acc;
  logic                        cfg_wr;
  logic [8:0]                  div_sh;
  logic                        div_ge;
  logic [swog_pkg::SINE_W-1:0] mul_a;
  logic [7:0]                  mul_b;
  logic [swog_pkg::PROD_W-1:0] mul_p;
  logic                        mem_we;
  logic [AW-1:0]               mem_waddr;
  logic [15:0]                 mem_wdata;
  logic [15:0]                 wave_val;
  logic                        rd_in_range;
  logic [AW-1:0]               rd_addr;
  logic [8:0]                  next_phase;
  logic                        out_free;
  logic                        fill_more;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign pready    = 1'b1;
  assign cfg_wr    = psel && penable && pwrite && pready;
  assign out_valid = out_valid_r;
  assign out_line_value = out_line_value_r;
  assign out_line_echo  = out_line_echo_r;
  assign out_free  = !out_valid_r || !out_stall;

  always_comb begin
    case (paddr[4:2])
      swog_pkg::REG_START_LINE: prdata = {24'd0, reg_start_r};
      swog_pkg::REG_END_LINE:   prdata = {24'd0, reg_end_r};
      swog_pkg::REG_FREQUENCY:  prdata = {24'd0, reg_freq_r};
      swog_pkg::REG_AMPLITUDE:  prdata = {24'd0, reg_amp_r};
      swog_pkg::REG_DELAY:      prdata = {24'd0, reg_delay_r};
      swog_pkg::REG_APPLY_BG:   prdata = {31'd0, reg_apply_r};
      default:                  prdata = 32'd0;
    endcase
  end

  // restoring divider step for 256 / frequency
  assign div_sh = {div_rem_r, (div_cnt_r == 4'd8)};
  assign div_ge = (div_sh >= {1'b0, lat_freq_r});

  // shared multiplier
  always_comb begin
    if (state_r == ST_PHASE) begin
      mul_a = {1'b0, wave_phase_r};
      mul_b = lat_freq_r;
    end else begin
      mul_a = swog_pkg::sine_mag(theta_r[6:0]);
      mul_b = lat_amp_r;
    end
  end
  assign mul_p = swog_pkg::PROD_W'(mul_a * mul_b);

  assign wave_val  = neg_r ? (16'd0 - {8'd0, prod_r[15:8]}) : {8'd0, prod_r[15:8]};
  assign mem_wdata = wave_val + add_r;
  assign mem_we    = (state_r == ST_WR0) || (state_r == ST_WR1);
  always_comb begin
    if ((state_r == ST_WR1) || fill_bank_r) begin
      mem_waddr = BANK1_BASE + AW'(i_r);
    end else begin
      mem_waddr = AW'(i_r);
    end
  end

  assign rd_in_range = (in_line >= lat_start_r) && (in_line < lat_end_r) &&
                       ({1'b0, in_line} < LINES_9);
  assign rd_addr     = write_bank_r ? AW'(in_line) : (BANK1_BASE + AW'(in_line));
  assign next_phase  = {1'b0, wave_phase_r} + 9'd1;
  assign fill_more   = (i_r < lat_end_r) && ({1'b0, i_r} < LINES_9);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (in_acc && (in_cmd == swog_pkg::CMD_READ) && rd_in_range) begin
      mem_q_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reg_start_r <= 8'd0;
      reg_end_r   <= 8'd0;
      reg_freq_r  <= 8'd1;
      reg_amp_r   <= 8'd0;
      reg_delay_r <= 8'd0;
      reg_apply_r <= 1'b0;
    end else if (cfg_wr) begin
      case (paddr[4:2])
        swog_pkg::REG_START_LINE: reg_start_r <= pwdata[7:0];
        swog_pkg::REG_END_LINE:   reg_end_r   <= pwdata[7:0];
        swog_pkg::REG_FREQUENCY:  reg_freq_r  <= pwdata[7:0];
        swog_pkg::REG_AMPLITUDE:  reg_amp_r   <= pwdata[7:0];
        swog_pkg::REG_DELAY:      reg_delay_r <= pwdata[7:0];
        swog_pkg::REG_APPLY_BG:   reg_apply_r <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      lat_start_r   <= 8'd0;
      lat_end_r     <= 8'd0;
      lat_freq_r    <= 8'd1;
      lat_amp_r     <= 8'd0;
      lat_delay_r   <= 8'd0;
      lat_apply_r   <= 1'b0;
      active_r      <= 1'b0;
      write_bank_r  <= 1'b0;
      wave_phase_r  <= 8'd0;
      wave_length_r <= 9'd256;
      frames_left_r <= 8'd0;
      out_valid_r   <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall && (state_r != ST_RD)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            case (in_cmd)
              swog_pkg::CMD_START: begin
                lat_start_r   <= reg_start_r;
                lat_end_r     <= reg_end_r;
                lat_freq_r    <= reg_freq_r;
                lat_amp_r     <= reg_amp_r;
                lat_delay_r   <= reg_delay_r;
                lat_apply_r   <= reg_apply_r;
                active_r      <= 1'b1;
                write_bank_r  <= 1'b0;
                wave_phase_r  <= 8'd0;
                frames_left_r <= reg_delay_r;
                div_rem_r     <= 8'd0;
                div_quo_r     <= 8'd0;
                div_cnt_r     <= 4'd8;
                fill_bank_r   <= 1'b0;
                both_r        <= 1'b1;
                add_r         <= 16'd0;
                theta_r       <= '0;
                i_r           <= reg_start_r;
                state_r       <= ST_DIV;
              end
              swog_pkg::CMD_FRAME: begin
                if (active_r) begin
                  write_bank_r <= !write_bank_r;
                  fill_bank_r  <= !write_bank_r;
                  both_r       <= 1'b0;
                  add_r        <= lat_apply_r ? in_bg_offset : 16'd0;
                  i_r          <= lat_start_r;
                  state_r      <= ST_PHASE;
                end
              end
              swog_pkg::CMD_READ: begin
                in_range_r <= rd_in_range;
                rd_line_r  <= in_line;
                state_r    <= ST_RD;
              end
              default: ;
            endcase
          end
        end
        ST_DIV: begin
          div_rem_r <= div_ge ? 8'(div_sh - {1'b0, lat_freq_r}) : div_sh[7:0];
          div_quo_r <= {div_quo_r[6:0], div_ge};
          div_cnt_r <= div_cnt_r - 4'd1;
          if (div_cnt_r == 4'd0) begin
            wave_length_r <= (lat_freq_r == 8'd0) ? 9'd256 : {div_quo_r, div_ge};
            state_r       <= ST_HEAD;
          end
        end
        ST_PHASE: begin
          theta_r <= mul_p[swog_pkg::THETA_W-1:0];
          if (frames_left_r != 8'd0) begin
            frames_left_r <= frames_left_r - 8'd1;
          end else begin
            frames_left_r <= lat_delay_r;
            wave_phase_r  <= ((next_phase == wave_length_r) || next_phase[8]) ?
                             8'd0 : next_phase[7:0];
          end
          state_r <= ST_HEAD;
        end
        ST_HEAD: begin
          state_r <= fill_more ? ST_MUL : ST_IDLE;
        end
        ST_MUL: begin
          prod_r  <= mul_p;
          neg_r   <= theta_r[swog_pkg::THETA_W-1];
          state_r <= ST_WR0;
        end
        ST_WR0: begin
          if (both_r) begin
            state_r <= ST_WR1;
          end else begin
            i_r     <= i_r + 8'd1;
            theta_r <= theta_r + lat_freq_r;
            state_r <= ST_HEAD;
          end
        end
        ST_WR1: begin
          i_r     <= i_r + 8'd1;
          theta_r <= theta_r + lat_freq_r;
          state_r <= ST_HEAD;
        end
        ST_RD: begin
          if (out_free) begin
            out_valid_r      <= 1'b1;
            out_line_value_r <= in_range_r ? mem_q_r : 16'd0;
            out_line_echo_r  <= rd_line_r;
            state_r          <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (i_r >= lat_start_r) && fill_more)
    else $error("line store written outside the latched range");

  a_phase_below_length: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> ({1'b0, wave_phase_r} < wave_length_r))
    else $error("wave phase not below wave length");

  a_read_goes_rd: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (in_cmd == swog_pkg::CMD_READ)) |=> (state_r == ST_RD))
    else $error("read transaction did not enter read state");

  a_result_from_rd: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == ST_RD))
    else $error("result raised outside a read");

endmodule

/* sim/tb_scanline_wave_offset_generator.sv */
// ============================================================================
// tb_scanline_wave_offset_generator
// Programs the wave registers over APB and sends start, frame, read and
// unused commands, with random gaps on the input side and random stalls on
// the result side. An untimed model of the two scanline banks predicts reads
// without a fixed value; each read is checked field by field, in order.
// ============================================================================
module tb_scanline_wave_offset_generator;

  localparam logic [1:0] CMD_UNUSED    = 2'd3;
  localparam int         SETTLE_CYCLES = 1200;
  localparam int         CYCLE_LIMIT   = 3_000_000;
  localparam int         NUM_PHASES    = 24;
  localparam int         NUM_DIRECTED  = 23;

  localparam logic [8:0] SINE_TAB [65] = '{
    9'd0,   9'd6,   9'd12,  9'd18,  9'd25,  9'd31,  9'd37,  9'd43,
    9'd49,  9'd56,  9'd62,  9'd68,  9'd74,  9'd80,  9'd86,  9'd92,
    9'd97,  9'd103, 9'd109, 9'd115, 9'd120, 9'd126, 9'd131, 9'd136,
    9'd142, 9'd147, 9'd152, 9'd157, 9'd162, 9'd167, 9'd171, 9'd176,
    9'd181, 9'd185, 9'd189, 9'd193, 9'd197, 9'd201, 9'd205, 9'd209,
    9'd212, 9'd216, 9'd219, 9'd222, 9'd225, 9'd228, 9'd231, 9'd234,
    9'd236, 9'd238, 9'd241, 9'd243, 9'd244, 9'd246, 9'd248, 9'd249,
    9'd251, 9'd252, 9'd253, 9'd254, 9'd254, 9'd255, 9'd255, 9'd255,
    9'd256
  };

  typedef struct packed {
    logic [7:0] first_line;
    logic [7:0] end_line;
    logic [7:0] freq;
    logic [7:0] amp;
    logic [7:0] delay;
    logic       apply_bg;
  } wave_cfg_t;

  typedef struct packed {
    logic [15:0] value;
    logic [7:0]  echo;
  } line_result_t;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [15:0] bg;
    logic [7:0]  line;
    logic        fixed;
    logic [15:0] value;
  } dir_row_t;

  // directed setting: first 100, end 255, freq 255, amp 255, delay 1, bg on
  localparam dir_row_t DIRECTED [NUM_DIRECTED] = '{
    '{swog_pkg::CMD_FRAME, 16'hFFFF, 8'd0,   1'b0, 16'h0000},  // frame before any start
    '{swog_pkg::CMD_READ,  16'h0000, 8'd0,   1'b1, 16'h0000},
    '{swog_pkg::CMD_READ,  16'h0000, 8'd255, 1'b1, 16'h0000},
    '{CMD_UNUSED,          16'hFFFF, 8'd255, 1'b0, 16'h0000},
    '{swog_pkg::CMD_START, 16'h0000, 8'd0,   1'b0, 16'h0000},
    '{swog_pkg::CMD_READ,  16'h0000, 8'd100, 1'b0, 16'h0000},
    '{swog_pkg::CMD_READ,  16'h0000, 8'd254, 1'b0, 16'h0000},
    '{swog_pkg::CMD_READ,  16'h0000, 8'd255, 1'b1, 16'h0000},  // end is exclusive
    '{swog_pkg::CMD_READ,  16'h0000, 8'd99,  1'b1, 16'h0000},
    '{swog_pkg::CMD_FRAME, 16'hFFFF, 8'd0,   1'b0, 16'h0000},
    '{swog_pkg::CMD_READ,  16'h0000, 8'd100, 1'b0, 16'h0000},
    '{swog_pkg::CMD_READ,  16'h0000, 8'd177, 1'b0, 16'h0000},
    '{swog_pkg::CMD_FRAME, 16'h0000, 8'd0,   1'b0, 16'h0000},
    '{swog_pkg::CMD_READ,  16'h0000, 8'd100, 1'b0, 16'h0000},
    '{swog_pkg::CMD_READ,  16'h0000, 8'd254, 1'b0, 16'h0000},
    '{swog_pkg::CMD_FRAME, 16'h8000, 8'd0,   1'b0, 16'h0000},
    '{swog_pkg::CMD_READ,  16'h0000, 8'd200, 1'b0, 16'h0000},
    '{swog_pkg::CMD_FRAME, 16'h0001, 8'd0,   1'b0, 16'h0000},
    '{swog_pkg::CMD_READ,  16'h0000, 8'd128, 1'b0, 16'h0000},
    '{CMD_UNUSED,          16'h0000, 8'd0,   1'b0, 16'h0000},
    '{swog_pkg::CMD_START, 16'h0000, 8'd0,   1'b0, 16'h0000},
    '{swog_pkg::CMD_READ,  16'h0000, 8'd0,   1'b1, 16'h0000},
    '{swog_pkg::CMD_READ,  16'h0000, 8'd150, 1'b0, 16'h0000}
  };

  logic        clk;
  logic        rst_n        = 1'b0;
  logic        in_valid     = 1'b0;
  logic        in_stall;
  logic [1:0]  in_cmd       = swog_pkg::CMD_START;
  logic [15:0] in_bg_offset = '0;
  logic [7:0]  in_line      = '0;
  logic        out_valid;
  logic        out_stall    = 1'b0;
  logic [15:0] out_line_value;
  logic [7:0]  out_line_echo;
  logic        psel         = 1'b0;
  logic        penable      = 1'b0;
  logic        pwrite       = 1'b0;
  logic [4:0]  paddr        = '0;
  logic [31:0] pwdata       = '0;
  logic [31:0] prdata;
  logic        pready;

  scanline_wave_offset_generator uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_cmd         (in_cmd),
    .in_bg_offset   (in_bg_offset),
    .in_line        (in_line),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_line_value (out_line_value),
    .out_line_echo  (out_line_echo),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  // model state
  wave_cfg_t    reg_file;
  wave_cfg_t    live;
  logic [15:0]  scroll_mem [2][256];
  logic         wr_bank;
  logic [7:0]   wave_phase;
  logic [8:0]   wave_len;
  logic [7:0]   frames_left;
  logic         wave_on;
  line_result_t line_values_due [$];

  int mismatch_count = 0;
  int cycle_count    = 0;
  int snd_idle       = 0;
  int rcv_idle       = 0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_scanline_wave_offset_generator: done, errors");
      $finish;
    end
  end

  function automatic logic [15:0] wave_sample(logic [7:0] k);
    logic [15:0] theta;
    int          mag;
    int          prod;
    theta = k * live.freq;
    if (theta[6:0] <= 64) mag = int'(SINE_TAB[theta[6:0]]);
    else mag = int'(SINE_TAB[128 - int'(theta[6:0])]);
    if (theta[7]) mag = -mag;
    prod = mag * int'(live.amp);
    return 16'(prod / 256);
  endfunction

  function automatic void refill_bank(logic bank, logic [7:0] ph, logic [15:0] add);
    logic [7:0] k;
    for (int i = int'(live.first_line); i < int'(live.end_line); i++) begin
      k = 8'(int'(ph) + i - int'(live.first_line));
      scroll_mem[bank][i] = wave_sample(k) + add;
    end
  endfunction

  function automatic void apply_command(logic [1:0] cmd, logic [15:0] bg);
    logic [8:0] next_phase;
    case (cmd)
      swog_pkg::CMD_START: begin
        live = reg_file;
        for (int b = 0; b < 2; b++)
          for (int i = 0; i < 256; i++) scroll_mem[b][i] = '0;
        wr_bank     = 1'b0;
        wave_phase  = '0;
        wave_len    = (live.freq != 0) ? 9'(256 / live.freq) : 9'd256;
        frames_left = live.delay;
        wave_on     = 1'b1;
        refill_bank(1'b0, 8'd0, 16'd0);
        refill_bank(1'b1, 8'd0, 16'd0);
      end
      swog_pkg::CMD_FRAME: begin
        if (wave_on) begin
          wr_bank = ~wr_bank;
          refill_bank(wr_bank, wave_phase, live.apply_bg ? bg : 16'd0);
          if (frames_left != 0) begin
            frames_left--;
          end else begin
            frames_left = live.delay;
            next_phase  = {1'b0, wave_phase} + 9'd1;
            if (next_phase == wave_len || next_phase >= 9'd256) next_phase = '0;
            wave_phase = next_phase[7:0];
          end
        end
      end
      default: ;
    endcase
  endfunction

  function automatic logic [15:0] line_lookup(logic [7:0] ln);
    if (ln >= live.first_line && ln < live.end_line) return scroll_mem[~wr_bank][ln];
    return 16'd0;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    if (mismatch_count < 200)
      $display("MISMATCH %s: got %0h, want %0h (cycle %0d)", what, got, want, cycle_count);
    mismatch_count++;
  endtask

  // result side: check each transaction, then pick the next stall
  always @(posedge clk) begin
    line_result_t due;
    if (rst_n && out_valid && !out_stall) begin
      if (line_values_due.size() == 0) begin
        report_mismatch("result with nothing pending, line_value", out_line_value, 0);
      end else begin
        due = line_values_due.pop_front();
        if (out_line_value !== due.value)
          report_mismatch($sformatf("line %0d line_value", due.echo), out_line_value, due.value);
        if (out_line_echo !== due.echo)
          report_mismatch("line_echo", out_line_echo, due.echo);
      end
    end
    out_stall <= ($urandom_range(99) < rcv_idle);
  end

  task automatic send_item(logic [1:0] cmd, logic [15:0] bg, logic [7:0] ln,
                           logic fixed, logic [15:0] fixed_value);
    line_result_t due;
    if ($urandom_range(99) < snd_idle) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < snd_idle);
    end
    in_valid     <= 1'b1;
    in_cmd       <= cmd;
    in_bg_offset <= bg;
    in_line      <= ln;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (cmd == swog_pkg::CMD_READ) begin
      due.value = fixed ? fixed_value : line_lookup(ln);
      due.echo  = ln;
      line_values_due.push_back(due);
    end else begin
      apply_command(cmd, bg);
    end
  endtask

  // drain all reads, then give a start or full-frame refill time to finish
  task automatic settle_idle();
    in_valid <= 1'b0;
    while (line_values_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [7:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {24'd0, value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      swog_pkg::REG_START_LINE: reg_file.first_line = value;
      swog_pkg::REG_END_LINE:   reg_file.end_line   = value;
      swog_pkg::REG_FREQUENCY:  reg_file.freq       = value;
      swog_pkg::REG_AMPLITUDE:  reg_file.amp        = value;
      swog_pkg::REG_DELAY:      reg_file.delay      = value;
      swog_pkg::REG_APPLY_BG:   reg_file.apply_bg   = value[0];
      default: ;
    endcase
  endtask

  task automatic load_setting(wave_cfg_t s);
    write_reg(swog_pkg::REG_START_LINE, s.first_line);
    write_reg(swog_pkg::REG_END_LINE, s.end_line);
    write_reg(swog_pkg::REG_FREQUENCY, s.freq);
    write_reg(swog_pkg::REG_AMPLITUDE, s.amp);
    write_reg(swog_pkg::REG_DELAY, s.delay);
    write_reg(swog_pkg::REG_APPLY_BG, {7'd0, s.apply_bg});
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  initial begin
    wave_cfg_t   s;
    int          n_items;
    int          frame_pct;
    int          start_pct;
    int          r;
    logic [15:0] bg;
    logic [7:0]  ln;

    reg_file = '{8'd0, 8'd0, 8'd1, 8'd0, 8'd0, 1'b0};
    live     = reg_file;
    for (int b = 0; b < 2; b++)
      for (int i = 0; i < 256; i++) scroll_mem[b][i] = '0;
    wr_bank     = 1'b0;
    wave_phase  = '0;
    wave_len    = 9'd256;
    frames_left = '0;
    wave_on     = 1'b0;
    snd_idle    = 7;
    rcv_idle    = 72;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    load_setting('{8'd100, 8'd255, 8'd255, 8'd255, 8'd1, 1'b1});
    for (int i = 0; i < NUM_DIRECTED; i++)
      send_item(DIRECTED[i].cmd, DIRECTED[i].bg, DIRECTED[i].line,
                DIRECTED[i].fixed, DIRECTED[i].value);

    for (int p = 0; p < NUM_PHASES; p++) begin
      settle_idle();
      if (p == 8) begin
        snd_idle = 72;
        rcv_idle = 7;
      end else if (p == 16) begin
        snd_idle = 0;
        rcv_idle = 0;
      end
      case (p)
        0: s = '{8'd0,   8'd255, 8'd1,   8'd255, 8'd0,   1'b1};
        1: s = '{8'd255, 8'd0,   8'd255, 8'd255, 8'd255, 1'b1};  // empty range
        2: s = '{8'd5,   8'd30,  8'd0,   8'd255, 8'd2,   1'b1};  // zero frequency
        3: s = '{8'd200, 8'd216, 8'd1,   8'd200, 8'd0,   1'b0};  // full phase wrap
        4: s = '{8'd0,   8'd255, 8'd128, 8'd255, 8'd1,   1'b1};
        default: begin
          s.first_line = 8'($urandom_range(255));
          case ($urandom_range(9))
            0: s.end_line = 8'($urandom_range(255));
            1: s.end_line = 8'($urandom_range(s.first_line));
            default: s.end_line = (s.first_line > 8'd231) ? 8'd255
                                  : s.first_line + 8'($urandom_range(24, 1));
          endcase
          case ($urandom_range(7))
            0:       s.freq = 8'd0;
            1, 2:    s.freq = 8'($urandom_range(8, 1));
            default: s.freq = 8'($urandom_range(255, 1));
          endcase
          s.amp      = 8'($urandom_range(255));
          s.delay    = ($urandom_range(3) == 0) ? 8'($urandom_range(255))
                                                : 8'($urandom_range(2));
          s.apply_bg = 1'($urandom_range(1));
        end
      endcase
      n_items   = (p == 3) ? 360 : 60;
      frame_pct = (p == 3) ? 80 : 35;
      start_pct = (p == 3) ? 0 : 4;

      load_setting(s);
      send_item(swog_pkg::CMD_START, 16'($urandom), 8'($urandom), 1'b0, '0);
      repeat (n_items) begin
        r  = $urandom_range(99);
        bg = ($urandom_range(7) == 0) ? 16'h0000
           : ($urandom_range(6) == 0) ? 16'hFFFF : 16'($urandom);
        if (r < frame_pct) begin
          send_item(swog_pkg::CMD_FRAME, bg, 8'($urandom), 1'b0, '0);
        end else if (r < frame_pct + start_pct) begin
          send_item(swog_pkg::CMD_START, bg, 8'($urandom), 1'b0, '0);
        end else if (r < frame_pct + start_pct + 3) begin
          send_item(CMD_UNUSED, bg, 8'($urandom), 1'b0, '0);
        end else begin
          if (s.end_line > s.first_line && $urandom_range(9) < 7)
            ln = 8'($urandom_range(s.end_line - 1, s.first_line));
          else
            ln = 8'($urandom_range(255));
          send_item(swog_pkg::CMD_READ, bg, ln, 1'b0, '0);
        end
      end
    end

    settle_idle();
    if (mismatch_count == 0)
      $display("tb_scanline_wave_offset_generator: done, clean");
    else
      $display("tb_scanline_wave_offset_generator: done, errors");
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/swog_pkg.sv
hw/rtl/scanline_wave_offset_generator.sv
sim/tb_scanline_wave_offset_generator.sv
